// File: rtl/gas_pkg.sv
// shared types, constants and operation sequence for the gravity acceleration sum
`timescale 1ns / 1ps
`default_nettype none
package gas_pkg;

  localparam int unsigned POSITION_BITS_DEF = 44;
  localparam int unsigned MASS_BITS_DEF     = 42;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned ACCEL_W     = 64;

  localparam logic [CFG_INDEX_W-1:0] CFG_GRAVITY   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOFTENING = 8'd1;

  localparam logic [CFG_DATA_W-1:0] GRAVITY_RESET = 32'd286659003;

  typedef enum logic [1:0] {
    UNIT_MUL,
    UNIT_SQRT,
    UNIT_DIV,
    UNIT_ACC
  } unit_e;

  typedef enum logic [2:0] {
    MSEL_SOFT,
    MSEL_DSQ,
    MSEL_DEN,
    MSEL_GM,
    MSEL_NUM
  } msel_e;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam int unsigned OP_W = 4;
  localparam logic [OP_W-1:0] OP_SOFT  = 4'd0;
  localparam logic [OP_W-1:0] OP_DSQ_X = 4'd1;
  localparam logic [OP_W-1:0] OP_DSQ_Y = 4'd2;
  localparam logic [OP_W-1:0] OP_DSQ_Z = 4'd3;
  localparam logic [OP_W-1:0] OP_SQRT  = 4'd4;
  localparam logic [OP_W-1:0] OP_DEN   = 4'd5;
  localparam logic [OP_W-1:0] OP_GM    = 4'd6;
  localparam logic [OP_W-1:0] OP_NUM_X = 4'd7;
  localparam logic [OP_W-1:0] OP_DIV_X = 4'd8;
  localparam logic [OP_W-1:0] OP_ACC_X = 4'd9;
  localparam logic [OP_W-1:0] OP_NUM_Y = 4'd10;
  localparam logic [OP_W-1:0] OP_DIV_Y = 4'd11;
  localparam logic [OP_W-1:0] OP_ACC_Y = 4'd12;
  localparam logic [OP_W-1:0] OP_NUM_Z = 4'd13;
  localparam logic [OP_W-1:0] OP_DIV_Z = 4'd14;
  localparam logic [OP_W-1:0] OP_ACC_Z = 4'd15;

  typedef struct packed {
    unit_e      unit;
    msel_e      msel;
    logic [1:0] axis;
  } op_t;

  typedef struct packed {
    logic load;
    logic start;
    logic wb;
    logic emit;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic mul_idle;
    logic sqrt_idle;
    logic div_idle;
    logic last;
    logic out_busy;
  } status_t;

  function automatic op_t op_decode(input logic [OP_W-1:0] op);
    op_t d;
    d.unit = UNIT_MUL;
    d.msel = MSEL_SOFT;
    d.axis = AXIS_X;
    unique case (op)
      OP_SOFT: ;
      OP_DSQ_X: d.msel = MSEL_DSQ;
      OP_DSQ_Y: begin
        d.msel = MSEL_DSQ;
        d.axis = AXIS_Y;
      end
      OP_DSQ_Z: begin
        d.msel = MSEL_DSQ;
        d.axis = AXIS_Z;
      end
      OP_SQRT: d.unit = UNIT_SQRT;
      OP_DEN: d.msel = MSEL_DEN;
      OP_GM: d.msel = MSEL_GM;
      OP_NUM_X: d.msel = MSEL_NUM;
      OP_NUM_Y: begin
        d.msel = MSEL_NUM;
        d.axis = AXIS_Y;
      end
      OP_NUM_Z: begin
        d.msel = MSEL_NUM;
        d.axis = AXIS_Z;
      end
      OP_DIV_X: d.unit = UNIT_DIV;
      OP_DIV_Y: begin
        d.unit = UNIT_DIV;
        d.axis = AXIS_Y;
      end
      OP_DIV_Z: begin
        d.unit = UNIT_DIV;
        d.axis = AXIS_Z;
      end
      OP_ACC_X: d.unit = UNIT_ACC;
      OP_ACC_Y: begin
        d.unit = UNIT_ACC;
        d.axis = AXIS_Y;
      end
      OP_ACC_Z: begin
        d.unit = UNIT_ACC;
        d.axis = AXIS_Z;
      end
      default: ;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// File: rtl/gas_ctrl.sv
// sequencer that steps the datapath through one body's operations
`timescale 1ns / 1ps
`default_nettype none
module gas_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire gas_pkg::status_t status_i,
  output gas_pkg::cmd_t        cmd_o
);
  import gas_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [OP_W-1:0] op_q, op_d;
  op_t             dec;
  logic            unit_idle;
  logic            emit_now;

  always_comb begin
    dec = op_decode(op_q);
    emit_now = (op_q == OP_ACC_Z) && status_i.last;
    case (dec.unit)
      UNIT_MUL:  unit_idle = status_i.mul_idle;
      UNIT_SQRT: unit_idle = status_i.sqrt_idle;
      UNIT_DIV:  unit_idle = status_i.div_idle;
      default:   unit_idle = 1'b1;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.op   = dec;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = OP_SOFT;
          state_d    = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (dec.unit == UNIT_ACC) begin
          if (!(emit_now && status_i.out_busy)) begin
            cmd_o.start = 1'b1;
            cmd_o.emit  = emit_now;
            if (op_q == OP_ACC_Z) begin
              state_d = ST_IDLE;
            end else begin
              op_d = op_q + 4'd1;
            end
          end
        end else begin
          cmd_o.start = 1'b1;
          state_d     = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (unit_idle) begin
          cmd_o.wb = 1'b1;
          op_d     = op_q + 4'd1;
          state_d  = ST_ISSUE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_SOFT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/gas_dp.sv
// datapath: digit multiplier, square root, divider, saturating accumulators
`timescale 1ns / 1ps
`default_nettype none
module gas_dp #(
  parameter int unsigned POSITION_BITS = gas_pkg::POSITION_BITS_DEF,
  parameter int unsigned MASS_BITS     = gas_pkg::MASS_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire gas_pkg::cmd_t                      cmd_i,
  output gas_pkg::status_t                        status_o,
  input  wire logic [POSITION_BITS-1:0]           target_x_i,
  input  wire logic [POSITION_BITS-1:0]           target_y_i,
  input  wire logic [POSITION_BITS-1:0]           target_z_i,
  input  wire logic [POSITION_BITS-1:0]           source_x_i,
  input  wire logic [POSITION_BITS-1:0]           source_y_i,
  input  wire logic [POSITION_BITS-1:0]           source_z_i,
  input  wire logic [MASS_BITS-1:0]               source_mass_i,
  input  wire logic                               last_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [gas_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  wire logic [gas_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                               out_ready_i,
  output logic                                    out_valid_o,
  output logic [gas_pkg::ACCEL_W-1:0]             accel_x_o,
  output logic [gas_pkg::ACCEL_W-1:0]             accel_y_o,
  output logic [gas_pkg::ACCEL_W-1:0]             accel_z_o,
  output logic                                    saturated_o
);
  import gas_pkg::*;

  localparam int unsigned P        = POSITION_BITS;
  localparam int unsigned SQ_W     = (2 * P > 64) ? 2 * P : 64;
  localparam int unsigned R2_W     = SQ_W + 2;
  localparam int unsigned T_W      = R2_W + 32;
  localparam int unsigned RQ_W     = T_W / 2;
  localparam int unsigned BW       = ((RQ_W + 7) / 8) * 8;
  localparam int unsigned MUL_STEPS = BW / 8;
  localparam int unsigned GM_W     = CFG_DATA_W + MASS_BITS;
  localparam int unsigned AW       = (R2_W > GM_W) ? R2_W : GM_W;
  localparam int unsigned PROD_W   = AW + BW;
  localparam int unsigned DEN_W    = R2_W + RQ_W;
  localparam int unsigned GQ_W     = GM_W + P;
  localparam int unsigned NUM_W    = GQ_W + 32;
  localparam int unsigned DIV_W    = DEN_W + ACCEL_W;
  localparam int unsigned MCNT_W   = $clog2(MUL_STEPS + 1);
  localparam int unsigned SCNT_W   = $clog2(RQ_W + 1);
  localparam int unsigned DCNT_W   = $clog2(ACCEL_W + 1);

  localparam logic [ACCEL_W-1:0] S_MAX = {1'b0, {(ACCEL_W-1){1'b1}}};
  localparam logic [ACCEL_W-1:0] S_MIN = {1'b1, {(ACCEL_W-1){1'b0}}};

  // configuration registers
  logic [CFG_DATA_W-1:0] g_q, soft_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_q    <= GRAVITY_RESET;
      soft_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GRAVITY:   g_q    <= cfg_data_i;
        CFG_SOFTENING: soft_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item capture: per-axis magnitude and sign of target minus source
  logic [P-1:0] tgt [3];
  logic [P-1:0] src [3];
  logic [P:0]   diff [3];
  logic [P:0]   ndiff [3];
  logic [P-1:0] dmag_q [3];
  logic         dneg_q [3];
  logic [MASS_BITS-1:0] mass_q;
  logic         last_q;

  assign tgt[0] = target_x_i;
  assign tgt[1] = target_y_i;
  assign tgt[2] = target_z_i;
  assign src[0] = source_x_i;
  assign src[1] = source_y_i;
  assign src[2] = source_z_i;

  for (genvar k = 0; k < 3; k++) begin : g_diff
    assign diff[k]  = {tgt[k][P-1], tgt[k]} - {src[k][P-1], src[k]};
    assign ndiff[k] = ~diff[k] + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < 3; k++) begin
        dmag_q[k] <= diff[k][P] ? ndiff[k][P-1:0] : diff[k][P-1:0];
        dneg_q[k] <= diff[k][P];
      end
      mass_q <= source_mass_i;
      last_q <= last_i;
    end
  end

  // shared multiplier, eight multiplier bits per cycle, top digit first
  logic [AW-1:0]     mul_a_q, mul_a;
  logic [BW-1:0]     mul_b_q, mul_b;
  logic [PROD_W-1:0] mul_acc_q, mul_acc_d;
  logic [AW+7:0]     mul_part;
  logic [MCNT_W-1:0] mul_cnt_q;
  logic              mul_start;

  logic [R2_W-1:0]   r2_q;
  logic [DEN_W-1:0]  den_q;
  logic [GM_W-1:0]   gm_q;
  logic [RQ_W-1:0]   sq_root_q;

  assign mul_start = cmd_i.start && (cmd_i.op.unit == UNIT_MUL);

  always_comb begin
    case (cmd_i.op.msel)
      MSEL_SOFT: begin
        mul_a = AW'(soft_q);
        mul_b = BW'(soft_q);
      end
      MSEL_DSQ: begin
        mul_a = AW'(dmag_q[cmd_i.op.axis]);
        mul_b = BW'(dmag_q[cmd_i.op.axis]);
      end
      MSEL_DEN: begin
        mul_a = AW'(r2_q);
        mul_b = BW'(sq_root_q);
      end
      MSEL_GM: begin
        mul_a = AW'(mass_q);
        mul_b = BW'(g_q);
      end
      MSEL_NUM: begin
        mul_a = AW'(gm_q);
        mul_b = BW'(dmag_q[cmd_i.op.axis]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_part  = mul_a_q * mul_b_q[BW-1 -: 8];
  assign mul_acc_d = {mul_acc_q[PROD_W-9:0], 8'd0} + PROD_W'(mul_part);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_cnt_q <= '0;
    end else if (mul_start) begin
      mul_cnt_q <= MCNT_W'(MUL_STEPS);
    end else if (mul_cnt_q != '0) begin
      mul_cnt_q <= mul_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_start) begin
      mul_a_q   <= mul_a;
      mul_b_q   <= mul_b;
      mul_acc_q <= '0;
    end else if (mul_cnt_q != '0) begin
      mul_acc_q <= mul_acc_d;
      mul_b_q   <= {mul_b_q[BW-9:0], 8'd0};
    end
  end

  // integer square root of r2 * 2^32, two radicand bits per cycle
  logic [T_W-1:0]    sq_rad_q;
  logic [RQ_W+1:0]   sq_rem_q;
  logic [RQ_W+3:0]   sq_rem_sh, sq_trial, sq_diff;
  logic              sq_ge;
  logic [SCNT_W-1:0] sq_cnt_q;
  logic              sq_start;

  assign sq_start  = cmd_i.start && (cmd_i.op.unit == UNIT_SQRT);
  assign sq_rem_sh = {sq_rem_q, sq_rad_q[T_W-1 -: 2]};
  assign sq_trial  = {2'b00, sq_root_q, 2'b01};
  assign sq_ge     = sq_rem_sh >= sq_trial;
  assign sq_diff   = sq_rem_sh - sq_trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_cnt_q <= '0;
    end else if (sq_start) begin
      sq_cnt_q <= SCNT_W'(RQ_W);
    end else if (sq_cnt_q != '0) begin
      sq_cnt_q <= sq_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_start) begin
      sq_rad_q  <= {r2_q, 32'd0};
      sq_rem_q  <= '0;
      sq_root_q <= '0;
    end else if (sq_cnt_q != '0) begin
      sq_rad_q  <= {sq_rad_q[T_W-3:0], 2'b00};
      sq_rem_q  <= sq_ge ? sq_diff[RQ_W+1:0] : sq_rem_sh[RQ_W+1:0];
      sq_root_q <= {sq_root_q[RQ_W-2:0], sq_ge};
    end
  end

  // restoring divider, one quotient bit per cycle; top bit set means clamp
  logic [NUM_W-1:0]   div_rem_q;
  logic [DIV_W-1:0]   div_den_q;
  logic [ACCEL_W-1:0] div_quo_q;
  logic [DCNT_W-1:0]  div_cnt_q;
  logic               div_ge;
  logic               div_start;

  assign div_start = cmd_i.start && (cmd_i.op.unit == UNIT_DIV);
  assign div_ge    = DIV_W'(div_rem_q) >= div_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (div_start) begin
      div_cnt_q <= DCNT_W'(ACCEL_W);
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_den_q <= DIV_W'({den_q, {(ACCEL_W-1){1'b0}}});
      div_quo_q <= '0;
    end else if (div_cnt_q != '0) begin
      if (div_ge) begin
        div_rem_q <= div_rem_q - NUM_W'(div_den_q);
      end
      div_quo_q <= {div_quo_q[ACCEL_W-2:0], div_ge};
      div_den_q <= {1'b0, div_den_q[DIV_W-1:1]};
    end else if (cmd_i.wb && cmd_i.op.unit == UNIT_MUL && cmd_i.op.msel == MSEL_NUM) begin
      div_rem_q <= {GQ_W'(mul_acc_q), 32'd0};
    end
  end

  // multiplier results
  always_ff @(posedge clk_i) begin
    if (cmd_i.wb && cmd_i.op.unit == UNIT_MUL) begin
      case (cmd_i.op.msel)
        MSEL_SOFT: r2_q  <= R2_W'(mul_acc_q);
        MSEL_DSQ:  r2_q  <= r2_q + R2_W'(mul_acc_q);
        MSEL_DEN:  den_q <= DEN_W'(mul_acc_q);
        MSEL_GM:   gm_q  <= GM_W'(mul_acc_q);
        default: ;
      endcase
    end
  end

  // signed term from the quotient
  logic               r2_zero;
  logic               term_clamp;
  logic [ACCEL_W-1:0] term_mag, term_q, term_d;

  assign r2_zero    = (r2_q == '0);
  assign term_clamp = div_quo_q[ACCEL_W-1] && !r2_zero;
  assign term_mag   = div_quo_q[ACCEL_W-1] ? S_MAX : div_quo_q;

  always_comb begin
    if (r2_zero) begin
      term_d = '0;
    end else if (dneg_q[cmd_i.op.axis]) begin
      term_d = term_mag;
    end else begin
      term_d = ~term_mag + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb && cmd_i.op.unit == UNIT_DIV) begin
      term_q <= term_d;
    end
  end

  // saturating accumulators and result register
  logic [ACCEL_W-1:0] sum_q [3];
  logic               ovf_q;
  logic [ACCEL_W-1:0] sum_sel, sum_res;
  logic [ACCEL_W:0]   sum_wide;
  logic               sum_ovf;
  logic               acc_en;
  logic               out_valid_q;
  logic [ACCEL_W-1:0] out_x_q, out_y_q, out_z_q;
  logic               out_sat_q;

  assign acc_en   = cmd_i.start && (cmd_i.op.unit == UNIT_ACC);
  assign sum_sel  = sum_q[cmd_i.op.axis];
  assign sum_wide = {sum_sel[ACCEL_W-1], sum_sel} + {term_q[ACCEL_W-1], term_q};
  assign sum_ovf  = sum_wide[ACCEL_W] != sum_wide[ACCEL_W-1];
  assign sum_res  = sum_ovf ? (sum_wide[ACCEL_W] ? S_MIN : S_MAX) : sum_wide[ACCEL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= '0;
      end
      ovf_q <= 1'b0;
    end else if (acc_en && cmd_i.emit) begin
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= '0;
      end
      ovf_q <= 1'b0;
    end else if (acc_en) begin
      sum_q[cmd_i.op.axis] <= sum_res;
      ovf_q <= ovf_q | sum_ovf;
    end else if (cmd_i.wb && cmd_i.op.unit == UNIT_DIV) begin
      ovf_q <= ovf_q | term_clamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc_en && cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_en && cmd_i.emit) begin
      out_x_q   <= sum_q[0];
      out_y_q   <= sum_q[1];
      out_z_q   <= sum_res;
      out_sat_q <= ovf_q | sum_ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign accel_x_o   = out_x_q;
  assign accel_y_o   = out_y_q;
  assign accel_z_o   = out_z_q;
  assign saturated_o = out_sat_q;

  assign status_o.mul_idle  = (mul_cnt_q == '0);
  assign status_o.sqrt_idle = (sq_cnt_q == '0);
  assign status_o.div_idle  = (div_cnt_q == '0);
  assign status_o.last      = last_q;
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

endmodule
`default_nettype wire

// File: rtl/gravity_acceleration_sum.sv
// top level of the softened gravity acceleration accumulator
//
// Each input transaction on the s_axis group is one attracting body plus the
// target position; its softened acceleration term is added to three running
// sums. The transaction with tlast set closes the run: the sums and the
// saturation flag leave as one m_axis transaction and the sums clear.
// Bodies are handled one at a time. At the default widths, between acceptance
// and the next tready a body goes through nine products on the shared
// eight-bit-digit multiplier, a 61-step square root and three 64-step
// divisions, plus three accumulate steps; the divider and square root take
// the bulk of that time.
// A finished result sits in an output register; the next body is accepted
// while it waits. If the receiver stalls and a second run closes, the block
// holds its final accumulate step until the first result is taken.
// The cfg port is always ready; write it only while no body is in flight.
// Reset clears the sums and the flag, sets G to its default and softening
// to zero; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module gravity_acceleration_sum #(
  parameter int unsigned POSITION_BITS = gas_pkg::POSITION_BITS_DEF,
  parameter int unsigned MASS_BITS     = gas_pkg::MASS_BITS_DEF
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       s_axis_tvalid_i,
  output logic                                            s_axis_tready_o,
  // target_x, target_y, target_z, source_x, source_y, source_z, source_mass
  input  wire logic [((6*POSITION_BITS+MASS_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  input  wire logic                                       s_axis_tlast_i,
  output logic                                            m_axis_tvalid_o,
  input  wire logic                                       m_axis_tready_i,
  // accel_x, accel_y, accel_z
  output logic [3*gas_pkg::ACCEL_W-1:0]                   m_axis_tdata_o,
  // saturated
  output logic                                            m_axis_tuser_o,
  input  wire logic                                       cfg_valid_i,
  output logic                                            cfg_ready_o,
  input  wire logic [gas_pkg::CFG_INDEX_W-1:0]            cfg_index_i,
  input  wire logic [gas_pkg::CFG_DATA_W-1:0]             cfg_data_i
);
  import gas_pkg::*;

  localparam int unsigned P = POSITION_BITS;

  cmd_t    cmd;
  status_t status;
  logic [ACCEL_W-1:0] accel_x, accel_y, accel_z;

  assign cfg_ready_o = 1'b1;

  gas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gas_dp #(
    .POSITION_BITS (POSITION_BITS),
    .MASS_BITS     (MASS_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .target_x_i    (s_axis_tdata_i[0*P +: P]),
    .target_y_i    (s_axis_tdata_i[1*P +: P]),
    .target_z_i    (s_axis_tdata_i[2*P +: P]),
    .source_x_i    (s_axis_tdata_i[3*P +: P]),
    .source_y_i    (s_axis_tdata_i[4*P +: P]),
    .source_z_i    (s_axis_tdata_i[5*P +: P]),
    .source_mass_i (s_axis_tdata_i[6*P +: MASS_BITS]),
    .last_i        (s_axis_tlast_i),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .accel_x_o     (accel_x),
    .accel_y_o     (accel_y),
    .accel_z_o     (accel_z),
    .saturated_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {accel_z, accel_y, accel_x};

endmodule
`default_nettype wire
